// ===== src/bllow_pkg.sv =====
// Shared types, widths and reset constants for the battery level low detector.
package bllow_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned PctW    = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DvdW    = SampleW + PctW;
  localparam int unsigned QuoW    = PctW;
  localparam int unsigned CntW    = $clog2(QuoW + 1);

  localparam logic [SampleW-1:0] FullLevelRst    = 16'd4100;
  localparam logic [SampleW-1:0] EmptyIdleRst    = 16'd3200;
  localparam logic [SampleW-1:0] EmptyRunningRst = 16'd2900;
  localparam logic [PctW-1:0]    EnterIdleRst    = 7'd50;
  localparam logic [PctW-1:0]    EnterRunningRst = 7'd42;
  localparam logic [PctW-1:0]    ClearIdleRst    = 7'd60;
  localparam logic [PctW-1:0]    PctFull         = 7'd100;
  localparam logic [PctW-1:0]    PctEmpty        = 7'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FULL_LEVEL        = 3'd0,
    CFG_EMPTY_IDLE        = 3'd1,
    CFG_EMPTY_RUNNING     = 3'd2,
    CFG_ENTER_IDLE        = 3'd3,
    CFG_ENTER_RUNNING     = 3'd4,
    CFG_CLEAR_IDLE        = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP_IDLE,
    ST_DIV_IDLE,
    ST_PREP_RUN,
    ST_DIV_RUN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic               start;
    logic [DvdW-1:0]    dividend;
    logic [SampleW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [QuoW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/bllow_div.sv =====
// Restoring divider, one quotient bit per cycle, for quotients below 2^QuoW.
module bllow_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bllow_pkg::div_req_t req_i,
  output bllow_pkg::div_rsp_t rsp_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [bllow_pkg::CntW-1:0]          cnt_q, cnt_d;
  logic [bllow_pkg::SampleW-1:0]       rem_q, rem_d;
  logic [bllow_pkg::QuoW-1:0]          dvd_q, dvd_d;
  logic [bllow_pkg::QuoW-1:0]          quo_q, quo_d;
  logic [bllow_pkg::SampleW-1:0]       dsr_q, dsr_d;
  logic [bllow_pkg::SampleW:0]         trial;
  logic [bllow_pkg::SampleW:0]         diff;
  logic                                fits;

  // remainder stays below the divisor, so the trial value needs one extra bit
  assign trial = {rem_q, dvd_q[bllow_pkg::QuoW-1]};
  assign fits  = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = bllow_pkg::CntW'(bllow_pkg::QuoW);
      rem_d  = req_i.dividend[bllow_pkg::DvdW-1:bllow_pkg::QuoW];
      dvd_d  = req_i.dividend[bllow_pkg::QuoW-1:0];
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[bllow_pkg::SampleW-1:0] : trial[bllow_pkg::SampleW-1:0];
      dvd_d = {dvd_q[bllow_pkg::QuoW-2:0], 1'b0};
      quo_d = {quo_q[bllow_pkg::QuoW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == bllow_pkg::CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o = '{busy: busy_q, done: done_q, quotient: quo_q};

endmodule

// ===== src/battery_level_low_detector_core.sv =====
// Battery level low detector: sequencer, config registers and result register.
//
// Input channel: sample_i and motor_running_i transfer when in_valid_i is high
// and in_stall_o is low. The block takes one sample at a time and holds
// in_stall_o high from the accepting edge until the result is in the output
// register. Output channel: out_valid_o with battery_low_o, level_percent_o,
// rest_average_o and rest_average_valid_o transfers when out_stall_i is low.
// Each sample is mapped to percent over the idle window and, only when the
// motor runs and the flag is clear, over the running window. Each window
// mapping either clamps or runs a shared 7-step restoring divider. An
// accepted sample passes the idle-window step, the running-window step when
// it is needed, and a final step that loads the output register; in_stall_o
// falls in the same cycle that the new result appears in the output register.
// A stalled result holds in the output register while the next sample is
// already accepted and worked on; that sample waits in its final step until
// the register is free. Reset clears the flag and the rest average, restores
// the default thresholds and levels, and leaves the output register empty.
// Write configuration only while no sample is in flight.
module battery_level_low_detector_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bllow_pkg::SampleW-1:0]       sample_i,
  input  logic                                motor_running_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                battery_low_o,
  output logic [bllow_pkg::PctW-1:0]          level_percent_o,
  output logic [bllow_pkg::SampleW-1:0]       rest_average_o,
  output logic                                rest_average_valid_o,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [bllow_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [bllow_pkg::SampleW-1:0]       cfg_data_i
);

  // configuration registers
  logic [bllow_pkg::SampleW-1:0] full_q, full_d;
  logic [bllow_pkg::SampleW-1:0] empty_idle_q, empty_idle_d;
  logic [bllow_pkg::SampleW-1:0] empty_run_q, empty_run_d;
  logic [bllow_pkg::PctW-1:0]    enter_idle_q, enter_idle_d;
  logic [bllow_pkg::PctW-1:0]    enter_run_q, enter_run_d;
  logic [bllow_pkg::PctW-1:0]    clear_idle_q, clear_idle_d;

  // sequencer and detector state
  bllow_pkg::state_e             state_q, state_d;
  logic                          low_flag_q, low_flag_d;
  logic                          rest_seen_q, rest_seen_d;
  logic [bllow_pkg::SampleW-1:0] rest_avg_q, rest_avg_d;

  // captured sample and per-window results
  logic [bllow_pkg::SampleW-1:0] sample_q, sample_d;
  logic                          running_q, running_d;
  logic [bllow_pkg::PctW-1:0]    pct_idle_q, pct_idle_d;
  logic [bllow_pkg::PctW-1:0]    pct_run_q, pct_run_d;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic                          out_low_q, out_low_d;
  logic [bllow_pkg::PctW-1:0]    out_pct_q, out_pct_d;
  logic [bllow_pkg::SampleW-1:0] out_avg_q, out_avg_d;
  logic                          out_seen_q, out_seen_d;

  // shared window datapath
  logic                          run_phase;
  logic [bllow_pkg::SampleW-1:0] empty_sel;
  logic [bllow_pkg::SampleW-1:0] span;
  logic [bllow_pkg::SampleW-1:0] diff;
  logic [bllow_pkg::DvdW-1:0]    diff_ext;
  logic [bllow_pkg::DvdW-1:0]    scaled;
  logic                          div_start;
  logic                          at_empty;
  logic                          at_full;
  logic                          clamped;
  logic [bllow_pkg::PctW-1:0]    clamp_pct;
  logic                          need_run;
  logic                          out_free;
  logic                          accept;
  logic [bllow_pkg::SampleW+1:0] avg_sum;
  logic                          flag_next;
  logic [bllow_pkg::PctW-1:0]    mode_pct;
  logic [bllow_pkg::PctW-1:0]    mode_enter;

  bllow_pkg::div_req_t           div_req;
  bllow_pkg::div_rsp_t           div_rsp;

  bllow_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign need_run = running_q && !low_flag_q;

  // Pick the window for the current phase; two subtracts, two compares and a
  // constant multiply by one hundred feed the divider.
  assign run_phase = (state_q == bllow_pkg::ST_PREP_RUN);
  assign empty_sel = run_phase ? empty_run_q : empty_idle_q;
  assign at_empty  = sample_q <= empty_sel;
  assign at_full   = sample_q >= full_q;
  assign clamped   = at_empty || at_full;
  assign clamp_pct = at_empty ? bllow_pkg::PctEmpty : bllow_pkg::PctFull;
  assign span      = full_q - empty_sel;
  assign diff      = sample_q - empty_sel;
  assign diff_ext  = {{bllow_pkg::PctW{1'b0}}, diff};

  // diff * 100 as shifts and adds: 64 + 32 + 4
  assign scaled  = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
  assign div_req = '{start: div_start, dividend: scaled, divisor: span};

  // rest average update: (3 * avg + sample) / 4, kept in 18 bits
  assign avg_sum = {1'b0, rest_avg_q, 1'b0} + {2'b00, rest_avg_q} + {2'b00, sample_q};

  // hysteresis: a set flag only clears on idle; a clear flag checks its mode
  assign mode_pct   = running_q ? pct_run_q : pct_idle_q;
  assign mode_enter = running_q ? enter_run_q : enter_idle_q;
  always_comb begin
    if (low_flag_q) begin
      flag_next = !(!running_q && (pct_idle_q >= clear_idle_q));
    end else begin
      flag_next = mode_pct <= mode_enter;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bllow_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bllow_pkg::ST_PREP_IDLE;
      end
      bllow_pkg::ST_PREP_IDLE: begin
        if (!clamped) begin
          state_d = bllow_pkg::ST_DIV_IDLE;
        end else if (need_run) begin
          state_d = bllow_pkg::ST_PREP_RUN;
        end else begin
          state_d = bllow_pkg::ST_FINISH;
        end
      end
      bllow_pkg::ST_DIV_IDLE: begin
        if (div_rsp.done) begin
          state_d = need_run ? bllow_pkg::ST_PREP_RUN : bllow_pkg::ST_FINISH;
        end
      end
      bllow_pkg::ST_PREP_RUN: begin
        state_d = clamped ? bllow_pkg::ST_FINISH : bllow_pkg::ST_DIV_RUN;
      end
      bllow_pkg::ST_DIV_RUN: begin
        if (div_rsp.done) state_d = bllow_pkg::ST_FINISH;
      end
      bllow_pkg::ST_FINISH: begin
        if (out_free) state_d = bllow_pkg::ST_IDLE;
      end
      default: state_d = bllow_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath updates
  always_comb begin
    in_stall_o    = 1'b1;
    div_start     = 1'b0;
    sample_d      = sample_q;
    running_d     = running_q;
    pct_idle_d    = pct_idle_q;
    pct_run_d     = pct_run_q;
    low_flag_d    = low_flag_q;
    rest_seen_d   = rest_seen_q;
    rest_avg_d    = rest_avg_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_low_d     = out_low_q;
    out_pct_d     = out_pct_q;
    out_avg_d     = out_avg_q;
    out_seen_d    = out_seen_q;
    unique case (state_q)
      bllow_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          sample_d  = sample_i;
          running_d = motor_running_i;
        end
      end
      bllow_pkg::ST_PREP_IDLE: begin
        if (clamped) begin
          pct_idle_d = clamp_pct;
        end else begin
          div_start = 1'b1;
        end
      end
      bllow_pkg::ST_DIV_IDLE: begin
        if (div_rsp.done) pct_idle_d = div_rsp.quotient;
      end
      bllow_pkg::ST_PREP_RUN: begin
        if (clamped) begin
          pct_run_d = clamp_pct;
        end else begin
          div_start = 1'b1;
        end
      end
      bllow_pkg::ST_DIV_RUN: begin
        if (div_rsp.done) pct_run_d = div_rsp.quotient;
      end
      bllow_pkg::ST_FINISH: begin
        // commit state and load the result only once the output register is free
        if (out_free) begin
          low_flag_d = flag_next;
          if (!running_q) begin
            rest_seen_d = 1'b1;
            rest_avg_d  = rest_seen_q ? avg_sum[bllow_pkg::SampleW+1:2] : sample_q;
          end
          out_valid_d = 1'b1;
          out_low_d   = flag_next;
          out_pct_d   = pct_idle_q;
          out_avg_d   = running_q ? rest_avg_q
                      : (rest_seen_q ? avg_sum[bllow_pkg::SampleW+1:2] : sample_q);
          out_seen_d  = rest_seen_q || !running_q;
        end
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  // configuration writes; indexes past the list drop
  always_comb begin
    full_d       = full_q;
    empty_idle_d = empty_idle_q;
    empty_run_d  = empty_run_q;
    enter_idle_d = enter_idle_q;
    enter_run_d  = enter_run_q;
    clear_idle_d = clear_idle_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        bllow_pkg::CFG_FULL_LEVEL:    full_d       = cfg_data_i;
        bllow_pkg::CFG_EMPTY_IDLE:    empty_idle_d = cfg_data_i;
        bllow_pkg::CFG_EMPTY_RUNNING: empty_run_d  = cfg_data_i;
        bllow_pkg::CFG_ENTER_IDLE:    enter_idle_d = cfg_data_i[bllow_pkg::PctW-1:0];
        bllow_pkg::CFG_ENTER_RUNNING: enter_run_d  = cfg_data_i[bllow_pkg::PctW-1:0];
        bllow_pkg::CFG_CLEAR_IDLE:    clear_idle_d = cfg_data_i[bllow_pkg::PctW-1:0];
        default:                      full_d       = full_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bllow_pkg::ST_IDLE;
      low_flag_q   <= 1'b0;
      rest_seen_q  <= 1'b0;
      rest_avg_q   <= '0;
      out_valid_q  <= 1'b0;
      full_q       <= bllow_pkg::FullLevelRst;
      empty_idle_q <= bllow_pkg::EmptyIdleRst;
      empty_run_q  <= bllow_pkg::EmptyRunningRst;
      enter_idle_q <= bllow_pkg::EnterIdleRst;
      enter_run_q  <= bllow_pkg::EnterRunningRst;
      clear_idle_q <= bllow_pkg::ClearIdleRst;
    end else begin
      state_q      <= state_d;
      low_flag_q   <= low_flag_d;
      rest_seen_q  <= rest_seen_d;
      rest_avg_q   <= rest_avg_d;
      out_valid_q  <= out_valid_d;
      full_q       <= full_d;
      empty_idle_q <= empty_idle_d;
      empty_run_q  <= empty_run_d;
      enter_idle_q <= enter_idle_d;
      enter_run_q  <= enter_run_d;
      clear_idle_q <= clear_idle_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    running_q  <= running_d;
    pct_idle_q <= pct_idle_d;
    pct_run_q  <= pct_run_d;
    out_low_q  <= out_low_d;
    out_pct_q  <= out_pct_d;
    out_avg_q  <= out_avg_d;
    out_seen_q <= out_seen_d;
  end

  assign out_valid_o          = out_valid_q;
  assign battery_low_o        = out_low_q;
  assign level_percent_o      = out_pct_q;
  assign rest_average_o       = out_avg_q;
  assign rest_average_valid_o = out_seen_q;

  // the divider is only started when it is free
  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // a transfer on the input always enters the idle-window step
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == bllow_pkg::ST_PREP_IDLE)
    else $error("accepted sample did not start");

  // the reported percent never exceeds one hundred
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_percent_o <= bllow_pkg::PctFull)
    else $error("level percent out of range");

  // once seeded, the rest average stays seeded
  a_seen_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rest_seen_q |=> rest_seen_q)
    else $error("rest average lost its seed");

endmodule
